>>> sv/rsf_pkg.sv
// Shared types and constants for the restart supervisor.
package rsf_pkg;

    localparam int MAX_UNITS_DEF = 32;
    localparam int UNIT_W        = 32;
    localparam int CNT_W         = 16;
    localparam int CODE_W        = 8;
    localparam int KINDS_W       = 64;
    localparam int UCNT_W        = 6;
    localparam int CFG_IDX_W     = 2;

    typedef enum logic [2:0] {
        PH_INIT     = 3'd0,
        PH_RUN      = 3'd1,
        PH_STOPPING = 3'd2,
        PH_RESTART  = 3'd3,
        PH_SHUTDOWN = 3'd4,
        PH_DONE     = 3'd5
    } phase_t;

    typedef enum logic [1:0] {
        CMD_POLL = 2'd0,
        CMD_STOP = 2'd1,
        CMD_ARM  = 2'd2
    } cmd_t;

    typedef enum logic [1:0] {
        ST_PENDING    = 2'd0,
        ST_FINISHED   = 2'd1,
        ST_NOT_ACTIVE = 2'd2,
        ST_ACCEPTED   = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        STRAT_ONE_FOR_ONE  = 2'd0,
        STRAT_ONE_FOR_ALL  = 2'd1,
        STRAT_REST_FOR_ONE = 2'd2
    } strategy_t;

    typedef enum logic [1:0] {
        KIND_PERMANENT = 2'd0,
        KIND_TRANSIENT = 2'd1,
        KIND_TEMPORARY = 2'd2
    } kind_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_STRATEGY      = 2'd0,
        CFG_RESTART_LIMIT = 2'd1,
        CFG_UNIT_COUNT    = 2'd2,
        CFG_RESTART_KINDS = 2'd3
    } cfg_idx_t;

    localparam logic [CODE_W-1:0] EXIT_NORMAL = 8'd0;
    localparam logic [CODE_W-1:0] EXIT_LIMIT  = 8'd1;

endpackage

>>> sv/restart_supervisor_fsm.sv
// Restart supervisor top level: command pipeline, phase machine and result register.
//
// Fault-recovery supervisor for up to MAX_UNITS units. Each request is a command
// (poll, stop or arm); each accepted request yields exactly one result. A command
// is taken every cycle while cmd_stall is low: it lands in an input register, the
// phase machine and the mask logic (priority pick of the lowest dead unit or failing
// start) settle it combinationally, and the result register holds the answer.
// res_valid rises once the request has moved from the input register into the
// result register; sustained rate is one request per cycle while res_stall is low.
// The result register parts the two channels: a stalled result holds one request
// in the input register, and cmd_stall rises only when both are full.
// Configuration writes (strategy, restart limit, unit_count, restart_kinds) take
// effect at the next clock and are expected only while no request is in flight.
// Stops issued in a step act only through the alive bits reported by later polls.
module restart_supervisor_fsm #(
    parameter int MAX_UNITS = rsf_pkg::MAX_UNITS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // configuration write port
    input  logic                            cfg_we,
    input  logic [rsf_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [rsf_pkg::KINDS_W-1:0]     cfg_data,
    // command channel
    input  logic                            cmd_valid,
    output logic                            cmd_stall,
    input  logic [1:0]                      command,
    input  logic [rsf_pkg::UNIT_W-1:0]      unit_alive,
    input  logic [rsf_pkg::UNIT_W-1:0]      unit_exit_ok,
    input  logic [rsf_pkg::UNIT_W-1:0]      start_fails,
    input  logic [rsf_pkg::CODE_W-1:0]      start_error,
    // result channel
    output logic                            res_valid,
    input  logic                            res_stall,
    output logic [rsf_pkg::UNIT_W-1:0]      start_mask,
    output logic [rsf_pkg::UNIT_W-1:0]      stop_mask,
    output logic [2:0]                      phase_now,
    output logic [1:0]                      status,
    output logic [rsf_pkg::CODE_W-1:0]      exit_code,
    output logic [rsf_pkg::CNT_W-1:0]       restarts_done
);

    localparam int UW = rsf_pkg::UNIT_W;
    localparam int CW = rsf_pkg::CNT_W;
    localparam int EW = rsf_pkg::CODE_W;
    localparam int NW = rsf_pkg::UCNT_W;

    // ---------------- configuration registers ----------------
    logic [1:0]                  strategy_reg;
    logic [CW-1:0]               restart_limit_reg;
    logic [NW-1:0]               unit_count_reg;
    logic [rsf_pkg::KINDS_W-1:0] restart_kinds_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            strategy_reg      <= 2'd0;
            restart_limit_reg <= 16'd3;
            unit_count_reg    <= '0;
            restart_kinds_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (rsf_pkg::cfg_idx_t'(cfg_index))
                rsf_pkg::CFG_STRATEGY:      strategy_reg      <= cfg_data[1:0];
                rsf_pkg::CFG_RESTART_LIMIT: restart_limit_reg <= cfg_data[CW-1:0];
                rsf_pkg::CFG_UNIT_COUNT:    unit_count_reg    <= cfg_data[NW-1:0];
                rsf_pkg::CFG_RESTART_KINDS: restart_kinds_reg <= cfg_data;
                default:                    strategy_reg      <= strategy_reg;
            endcase
        end
    end

    // ---------------- input register ----------------
    logic          ibuf_valid_reg, ibuf_valid_next;
    logic [1:0]    ibuf_cmd_reg;
    logic [UW-1:0] ibuf_alive_reg;
    logic [UW-1:0] ibuf_exit_ok_reg;
    logic [UW-1:0] ibuf_fails_reg;
    logic [EW-1:0] ibuf_err_reg;

    logic adv;     // input register moves into the result register
    logic load;    // new request taken

    assign adv       = ibuf_valid_reg && (!res_valid || !res_stall);
    assign cmd_stall = ibuf_valid_reg && !adv;
    assign load      = cmd_valid && !cmd_stall;

    always_comb
    begin
        if (load)
            ibuf_valid_next = 1'b1;
        else if (adv)
            ibuf_valid_next = 1'b0;
        else
            ibuf_valid_next = ibuf_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ibuf_valid_reg <= 1'b0;
        else
            ibuf_valid_reg <= ibuf_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            ibuf_cmd_reg     <= command;
            ibuf_alive_reg   <= unit_alive;
            ibuf_exit_ok_reg <= unit_exit_ok;
            ibuf_fails_reg   <= start_fails;
            ibuf_err_reg     <= start_error;
        end
    end

    // ---------------- supervisor state ----------------
    rsf_pkg::phase_t phase_reg, phase_next;
    logic            active_reg, active_next;
    logic [CW-1:0]   count_reg, count_next;
    logic [UW-1:0]   pending_reg, pending_next;
    logic [EW-1:0]   exit_reg, exit_next;

    // ---------------- decode ----------------
    logic [NW-1:0] n_units;
    logic [UW-1:0] um;          // units in use
    logic [UW-1:0] alive;
    logic [UW-1:0] want;        // dead unit would be restarted by its kind
    logic [UW-1:0] cand;
    logic [UW-1:0] cand_bit;
    logic [UW-1:0] init_fail_bit;
    logic [UW-1:0] rst_pend;
    logic [UW-1:0] rst_fail_bit;
    logic [UW-1:0] new_pending;
    logic          is_arm, is_stop;
    logic          run_hit, at_limit, pend_alive;

    assign n_units = (unit_count_reg > NW'(MAX_UNITS)) ? NW'(MAX_UNITS) : unit_count_reg;

    always_comb
    begin
        for (int i = 0; i < UW; i++)
        begin
            um[i] = (NW'(i) < n_units);
            case (rsf_pkg::kind_t'(restart_kinds_reg[2*i +: 2]))
                rsf_pkg::KIND_PERMANENT: want[i] = 1'b1;
                rsf_pkg::KIND_TRANSIENT: want[i] = !ibuf_exit_ok_reg[i];
                default:                 want[i] = 1'b0;
            endcase
        end
    end

    assign is_arm  = (ibuf_cmd_reg == rsf_pkg::CMD_ARM);
    assign is_stop = (ibuf_cmd_reg == rsf_pkg::CMD_STOP);
    assign alive   = ibuf_alive_reg & um;

    // lowest set bit picks: x & -x
    assign cand          = ~alive & um & want;
    assign cand_bit      = cand & (~cand + 1'b1);
    assign run_hit       = |cand;
    assign at_limit      = (count_reg >= restart_limit_reg);

    assign init_fail_bit = (ibuf_fails_reg & um) & (~(ibuf_fails_reg & um) + 1'b1);

    assign rst_pend      = pending_reg & um;
    assign rst_fail_bit  = (rst_pend & ibuf_fails_reg) & (~(rst_pend & ibuf_fails_reg) + 1'b1);

    assign pend_alive    = |(alive & pending_reg);

    // scope of a restart decision
    always_comb
    begin
        case (rsf_pkg::strategy_t'(strategy_reg))
            rsf_pkg::STRAT_ONE_FOR_ALL:  new_pending = um;
            rsf_pkg::STRAT_REST_FOR_ONE: new_pending = um & ~(cand_bit - 1'b1);
            default:                     new_pending = cand_bit;
        endcase
    end

    logic one_for_one;
    assign one_for_one = (strategy_reg != rsf_pkg::STRAT_ONE_FOR_ALL) &&
                         (strategy_reg != rsf_pkg::STRAT_REST_FOR_ONE);

    // ---------------- next phase ----------------
    always_comb
    begin
        phase_next  = phase_reg;
        active_next = active_reg;
        if (is_arm)
        begin
            phase_next  = rsf_pkg::PH_INIT;
            active_next = 1'b1;
        end
        else if (is_stop)
        begin
            if (active_reg)
                phase_next = rsf_pkg::PH_SHUTDOWN;
        end
        else if (active_reg)
        begin
            case (phase_reg)
                rsf_pkg::PH_INIT:
                    phase_next = (|init_fail_bit) ? rsf_pkg::PH_SHUTDOWN : rsf_pkg::PH_RUN;
                rsf_pkg::PH_RUN:
                begin
                    if (run_hit)
                    begin
                        if (at_limit)
                            phase_next = rsf_pkg::PH_SHUTDOWN;
                        else if (one_for_one || !(|(alive & new_pending)))
                            phase_next = rsf_pkg::PH_RESTART;
                        else
                            phase_next = rsf_pkg::PH_STOPPING;
                    end
                end
                rsf_pkg::PH_STOPPING:
                    if (!pend_alive)
                        phase_next = rsf_pkg::PH_RESTART;
                rsf_pkg::PH_RESTART:
                    phase_next = (|rst_fail_bit) ? rsf_pkg::PH_SHUTDOWN : rsf_pkg::PH_RUN;
                rsf_pkg::PH_SHUTDOWN:
                    if (alive == '0)
                    begin
                        phase_next  = rsf_pkg::PH_DONE;
                        active_next = 1'b0;
                    end
                default:
                    phase_next = phase_reg;
            endcase
        end
    end

    // ---------------- outputs and datapath ----------------
    logic [UW-1:0] start_m;
    logic [UW-1:0] stop_m;
    logic [1:0]    status_v;

    always_comb
    begin
        start_m      = '0;
        stop_m       = '0;
        status_v     = rsf_pkg::ST_PENDING;
        count_next   = count_reg;
        pending_next = pending_reg;
        exit_next    = exit_reg;
        if (is_arm)
        begin
            count_next   = '0;
            pending_next = '0;
            exit_next    = rsf_pkg::EXIT_NORMAL;
            status_v     = rsf_pkg::ST_ACCEPTED;
        end
        else if (!active_reg)
        begin
            status_v = rsf_pkg::ST_NOT_ACTIVE;
        end
        else if (is_stop)
        begin
            stop_m    = alive;
            exit_next = rsf_pkg::EXIT_NORMAL;
            status_v  = rsf_pkg::ST_ACCEPTED;
        end
        else
        begin
            case (phase_reg)
                rsf_pkg::PH_INIT:
                begin
                    if (|init_fail_bit)
                    begin
                        start_m   = init_fail_bit - 1'b1;
                        stop_m    = init_fail_bit - 1'b1;
                        exit_next = ibuf_err_reg;
                    end
                    else
                        start_m = um;
                end
                rsf_pkg::PH_RUN:
                begin
                    if (run_hit)
                    begin
                        if (at_limit)
                        begin
                            exit_next = rsf_pkg::EXIT_LIMIT;
                            stop_m    = alive;
                        end
                        else
                        begin
                            count_next   = count_reg + 1'b1;
                            pending_next = new_pending;
                            if (!one_for_one)
                                stop_m = alive & new_pending & ~cand_bit;
                        end
                    end
                end
                rsf_pkg::PH_STOPPING:
                    stop_m = '0;
                rsf_pkg::PH_RESTART:
                begin
                    if (|rst_fail_bit)
                    begin
                        start_m   = rst_pend & (rst_fail_bit - 1'b1);
                        stop_m    = (alive | (rst_pend & (rst_fail_bit - 1'b1))) & um;
                        exit_next = ibuf_err_reg;
                    end
                    else
                    begin
                        start_m      = rst_pend;
                        pending_next = '0;
                    end
                end
                rsf_pkg::PH_SHUTDOWN:
                    if (alive == '0)
                        status_v = rsf_pkg::ST_FINISHED;
                default:
                    status_v = rsf_pkg::ST_NOT_ACTIVE;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= rsf_pkg::PH_INIT;
            active_reg  <= 1'b0;
            count_reg   <= '0;
            pending_reg <= '0;
            exit_reg    <= rsf_pkg::EXIT_NORMAL;
        end
        else if (adv)
        begin
            phase_reg   <= phase_next;
            active_reg  <= active_next;
            count_reg   <= count_next;
            pending_reg <= pending_next;
            exit_reg    <= exit_next;
        end
    end

    // ---------------- result register ----------------
    logic res_valid_reg, res_valid_next;

    always_comb
    begin
        if (adv)
            res_valid_next = 1'b1;
        else if (res_stall)
            res_valid_next = res_valid_reg;
        else
            res_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_valid_reg <= 1'b0;
        else
            res_valid_reg <= res_valid_next;
    end

    logic [UW-1:0] start_mask_reg, stop_mask_reg;
    logic [2:0]    phase_now_reg;
    logic [1:0]    status_reg;
    logic [EW-1:0] exit_code_reg;
    logic [CW-1:0] restarts_done_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            start_mask_reg    <= start_m;
            stop_mask_reg     <= stop_m;
            phase_now_reg     <= phase_next;
            status_reg        <= status_v;
            exit_code_reg     <= exit_next;
            restarts_done_reg <= count_next;
        end
    end

    assign res_valid     = res_valid_reg;
    assign start_mask    = start_mask_reg;
    assign stop_mask     = stop_mask_reg;
    assign phase_now     = phase_now_reg;
    assign status        = status_reg;
    assign exit_code     = exit_code_reg;
    assign restarts_done = restarts_done_reg;

endmodule

>>> tb/tb.sv
// Testbench for the restart supervisor: directed table, then random command streams.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    // Codes that the package leaves unnamed but the block still has to take.
    localparam logic [1:0] CMD_RESERVED   = 2'd3;
    localparam logic [1:0] STRAT_RESERVED = 2'd3;
    localparam logic [1:0] KIND_NEVER     = 2'd3;

    // Far above the slowest correct run: about 1500 requests, each with sender gaps
    // and receiver stalls at 8 %, plus the drain before each register setting.
    localparam int CYCLE_LIMIT = 200_000;
    localparam int SETTINGS_N  = 8;
    localparam int PER_SETTING = 182;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [31:0] alive;
        logic [31:0] exit_ok;
        logic [31:0] fails;
        logic [7:0]  err;
    } request_t;

    typedef struct packed {
        logic [31:0] start;
        logic [31:0] stop;
        logic [2:0]  phase;
        logic [1:0]  status;
        logic [7:0]  code;
        logic [15:0] count;
    } outcome_t;

    // One line of the directed script: either a register setting or a request,
    // the latter optionally with its answer written out by hand.
    typedef struct {
        bit          is_setup;
        logic [1:0]  strat;
        logic [15:0] maxr;
        logic [5:0]  ucnt;
        logic [63:0] kinds;
        request_t    req;
        bit          typed;
        outcome_t    want;
    } script_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_index = rsf_pkg::CFG_STRATEGY;
    logic [63:0] cfg_data = '0;

    logic        cmd_valid = 1'b0;
    logic        cmd_stall;
    logic [1:0]  command = rsf_pkg::CMD_POLL;
    logic [31:0] unit_alive = '0;
    logic [31:0] unit_exit_ok = '0;
    logic [31:0] start_fails = '0;
    logic [7:0]  start_error = '0;

    logic        res_valid;
    logic        res_stall = 1'b0;
    logic [31:0] start_mask;
    logic [31:0] stop_mask;
    logic [2:0]  phase_now;
    logic [1:0]  status;
    logic [7:0]  exit_code;
    logic [15:0] restarts_done;

    restart_supervisor_fsm i_dut (.*);

    always #1 clk = ~clk;

    // Supervisor image kept by the testbench: registers and state.
    logic [1:0]       sv_strategy = rsf_pkg::STRAT_ONE_FOR_ONE;
    logic [15:0]      sv_max = 16'd3;
    logic [5:0]       sv_units = '0;
    logic [63:0]      sv_kinds = '0;
    rsf_pkg::phase_t  sv_phase = rsf_pkg::PH_INIT;
    bit               sv_armed = 1'b0;
    logic [15:0]      sv_count = '0;
    logic [31:0]      sv_pend = '0;
    logic [7:0]       sv_code = rsf_pkg::EXIT_NORMAL;

    outcome_t    outcome_q[$];
    script_row_t script[$];

    bit quiet = 1'b0;          // no idling on either side while set
    int mismatches = 0;
    int results_checked = 0;
    int requests_sent = 0;
    int restarts_seen = 0;
    int shutdowns_seen = 0;
    int cycles = 0;

    // Works out one step of the supervisor and advances the image.
    function automatic outcome_t supervisor_step(request_t r);
        int               n;
        int               i;
        int               victim;
        logic [31:0]      um;
        logic [31:0]      live;
        logic [31:0]      start_m;
        logic [31:0]      stop_m;
        logic [31:0]      bit_m;
        logic [1:0]       kind;
        rsf_pkg::status_t st;
        outcome_t         o;
        n = (sv_units > 6'd32) ? 32 : int'(sv_units);
        um = (n >= 32) ? 32'hFFFF_FFFF : ((32'd1 << n) - 32'd1);
        live = r.alive & um;
        start_m = '0;
        stop_m = '0;
        st = rsf_pkg::ST_PENDING;
        victim = -1;
        case (r.cmd)
            rsf_pkg::CMD_ARM:
            begin
                sv_armed = 1'b1;
                sv_phase = rsf_pkg::PH_INIT;
                sv_count = '0;
                sv_pend = '0;
                sv_code = rsf_pkg::EXIT_NORMAL;
                st = rsf_pkg::ST_ACCEPTED;
            end
            rsf_pkg::CMD_STOP:
            begin
                if (!sv_armed)
                begin
                    st = rsf_pkg::ST_NOT_ACTIVE;
                end
                else
                begin
                    stop_m = live;
                    sv_code = rsf_pkg::EXIT_NORMAL;
                    sv_phase = rsf_pkg::PH_SHUTDOWN;
                    st = rsf_pkg::ST_ACCEPTED;
                end
            end
            default:
            begin
                if (!sv_armed)
                begin
                    st = rsf_pkg::ST_NOT_ACTIVE;
                end
                else
                begin
                    case (sv_phase)
                        rsf_pkg::PH_INIT:
                        begin
                            // start units from 0 upward until the first failing one
                            victim = n;
                            for (i = n - 1; i >= 0; i--)
                                if (r.fails[i]) victim = i;
                            start_m = (victim >= 32) ? 32'hFFFF_FFFF
                                                     : ((32'd1 << victim) - 32'd1);
                            if (victim < n)
                            begin
                                stop_m = start_m;
                                sv_code = r.err;
                                sv_phase = rsf_pkg::PH_SHUTDOWN;
                            end
                            else
                            begin
                                sv_phase = rsf_pkg::PH_RUN;
                            end
                        end
                        rsf_pkg::PH_RUN:
                        begin
                            // lowest dead unit whose kind asks for a restart
                            for (i = n - 1; i >= 0; i--)
                            begin
                                kind = sv_kinds[2*i +: 2];
                                if (!live[i] && (kind == rsf_pkg::KIND_PERMANENT ||
                                    (kind == rsf_pkg::KIND_TRANSIENT && !r.exit_ok[i])))
                                    victim = i;
                            end
                            if (victim >= 0)
                            begin
                                bit_m = 32'd1 << victim;
                                if (sv_count >= sv_max)
                                begin
                                    sv_code = rsf_pkg::EXIT_LIMIT;
                                    stop_m = live;
                                    sv_phase = rsf_pkg::PH_SHUTDOWN;
                                end
                                else
                                begin
                                    sv_count = sv_count + 16'd1;
                                    restarts_seen++;
                                    case (sv_strategy)
                                        rsf_pkg::STRAT_ONE_FOR_ALL:
                                            sv_pend = um;
                                        rsf_pkg::STRAT_REST_FOR_ONE:
                                            sv_pend = um & ~(bit_m - 32'd1);
                                        default:
                                            sv_pend = bit_m;
                                    endcase
                                    stop_m = live & sv_pend & ~bit_m;
                                    sv_phase = ((live & sv_pend) == '0) ? rsf_pkg::PH_RESTART
                                                                        : rsf_pkg::PH_STOPPING;
                                end
                            end
                        end
                        rsf_pkg::PH_STOPPING:
                        begin
                            if ((live & sv_pend) == '0) sv_phase = rsf_pkg::PH_RESTART;
                        end
                        rsf_pkg::PH_RESTART:
                        begin
                            for (i = n - 1; i >= 0; i--)
                                if (sv_pend[i] && r.fails[i]) victim = i;
                            if (victim >= 0)
                            begin
                                // units started ahead of the failure are stopped too
                                start_m = sv_pend & ((32'd1 << victim) - 32'd1);
                                sv_code = r.err;
                                stop_m = (live | start_m) & um;
                                sv_phase = rsf_pkg::PH_SHUTDOWN;
                            end
                            else
                            begin
                                start_m = sv_pend & um;
                                sv_pend = '0;
                                sv_phase = rsf_pkg::PH_RUN;
                            end
                        end
                        rsf_pkg::PH_SHUTDOWN:
                        begin
                            if (live == '0)
                            begin
                                sv_armed = 1'b0;
                                sv_phase = rsf_pkg::PH_DONE;
                                st = rsf_pkg::ST_FINISHED;
                                shutdowns_seen++;
                            end
                        end
                        default:
                        begin
                            st = rsf_pkg::ST_NOT_ACTIVE;
                        end
                    endcase
                end
            end
        endcase
        o.start = start_m;
        o.stop = stop_m;
        o.phase = sv_phase;
        o.status = st;
        o.code = sv_code;
        o.count = sv_count;
        return o;
    endfunction

    task automatic flag_mismatch(input string field, input logic [31:0] got,
                                 input logic [31:0] want);
        if (mismatches < 40)
            $display("mismatch in %s of result %0d: got %h, want %h",
                     field, results_checked, got, want);
        mismatches++;
    endtask

    // Drives one request, holds it through stalls, then records its answer.
    task automatic send_request(input request_t r, input bit typed, input outcome_t want,
                                output outcome_t got);
        while (!quiet && $urandom_range(99) < 8)
        begin
            cmd_valid <= 1'b0;
            @(posedge clk);
        end
        cmd_valid <= 1'b1;
        command <= r.cmd;
        unit_alive <= r.alive;
        unit_exit_ok <= r.exit_ok;
        start_fails <= r.fails;
        start_error <= r.err;
        @(posedge clk);
        while (cmd_stall !== 1'b0) @(posedge clk);
        got = supervisor_step(r);
        outcome_q.push_back(typed ? want : got);
        requests_sent++;
    endtask

    // Registers change only with nothing in flight; all four go in back to back.
    task automatic apply_setup(input logic [1:0] strat, input logic [15:0] maxr,
                               input logic [5:0] ucnt, input logic [63:0] kinds);
        cmd_valid <= 1'b0;
        while (outcome_q.size() != 0) @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= rsf_pkg::CFG_STRATEGY;
        cfg_data <= {62'd0, strat};
        @(posedge clk);
        cfg_index <= rsf_pkg::CFG_RESTART_LIMIT;
        cfg_data <= {48'd0, maxr};
        @(posedge clk);
        cfg_index <= rsf_pkg::CFG_UNIT_COUNT;
        cfg_data <= {58'd0, ucnt};
        @(posedge clk);
        cfg_index <= rsf_pkg::CFG_RESTART_KINDS;
        cfg_data <= kinds;
        @(posedge clk);
        cfg_we <= 1'b0;
        sv_strategy = strat;
        sv_max = maxr;
        sv_units = ucnt;
        sv_kinds = kinds;
    endtask

    task automatic add_setup(input logic [1:0] strat, input logic [15:0] maxr,
                             input logic [5:0] ucnt, input logic [63:0] kinds);
        script_row_t row;
        row = '{default: '0};
        row.is_setup = 1'b1;
        row.strat = strat;
        row.maxr = maxr;
        row.ucnt = ucnt;
        row.kinds = kinds;
        script.push_back(row);
    endtask

    task automatic add_request(input request_t r, input bit typed, input outcome_t want);
        script_row_t row;
        row = '{default: '0};
        row.req = r;
        row.typed = typed;
        row.want = want;
        script.push_back(row);
    endtask

    // Result side: random stalls, and every accepted result is held against the
    // oldest expectation field by field.
    always @(posedge clk)
    begin
        outcome_t w;
        if (rst_n)
        begin
            if (res_valid === 1'b1 && res_stall === 1'b0)
            begin
                if (outcome_q.size() == 0)
                begin
                    flag_mismatch("result with nothing outstanding", start_mask, '0);
                end
                else
                begin
                    w = outcome_q.pop_front();
                    if (start_mask !== w.start)
                        flag_mismatch("start_mask", start_mask, w.start);
                    if (stop_mask !== w.stop)
                        flag_mismatch("stop_mask", stop_mask, w.stop);
                    if (phase_now !== w.phase)
                        flag_mismatch("phase_now", 32'(phase_now), 32'(w.phase));
                    if (status !== w.status)
                        flag_mismatch("status", 32'(status), 32'(w.status));
                    if (exit_code !== w.code)
                        flag_mismatch("exit_code", 32'(exit_code), 32'(w.code));
                    if (restarts_done !== w.count)
                        flag_mismatch("restarts_done", 32'(restarts_done), 32'(w.count));
                end
                results_checked++;
            end
            res_stall <= !quiet && ($urandom_range(99) < 8);
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycles, outcome_q.size());
            $display("status: fail");
            $finish;
        end
    end

    initial
    begin
        request_t    r;
        outcome_t    o;
        outcome_t    none;
        logic [31:0] units_up;
        logic [31:0] units_lagging;
        logic [1:0]  strat;
        logic [15:0] maxr;
        logic [5:0]  ucnt;
        logic [63:0] kinds;
        int          roll;

        none = '0;
        units_up = '0;
        units_lagging = '0;

        // ---- directed script ----------------------------------------------------
        // Out of reset: not armed, default registers (one-for-one, limit 3, no units).
        add_request(request_t'{rsf_pkg::CMD_POLL, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                               32'hFFFF_FFFF, 8'hFF},
                    1'b1, outcome_t'{32'h0, 32'h0, rsf_pkg::PH_INIT, rsf_pkg::ST_NOT_ACTIVE,
                                     rsf_pkg::EXIT_NORMAL, 16'd0});
        add_request(request_t'{rsf_pkg::CMD_STOP, 32'hFFFF_FFFF, 32'h0, 32'h0, 8'd2},
                    1'b1, outcome_t'{32'h0, 32'h0, rsf_pkg::PH_INIT, rsf_pkg::ST_NOT_ACTIVE,
                                     rsf_pkg::EXIT_NORMAL, 16'd0});
        // All 32 units, permanent, one restart allowed.
        add_setup(rsf_pkg::STRAT_ONE_FOR_ONE, 16'd1, 6'd32, 64'd0);
        add_request(request_t'{rsf_pkg::CMD_ARM, 32'h0, 32'h0, 32'h0, 8'd2},
                    1'b1, outcome_t'{32'h0, 32'h0, rsf_pkg::PH_INIT, rsf_pkg::ST_ACCEPTED,
                                     rsf_pkg::EXIT_NORMAL, 16'd0});
        add_request(request_t'{rsf_pkg::CMD_POLL, 32'h0, 32'h0, 32'h0, 8'd2},
                    1'b1, outcome_t'{32'hFFFF_FFFF, 32'h0, rsf_pkg::PH_RUN,
                                     rsf_pkg::ST_PENDING, rsf_pkg::EXIT_NORMAL, 16'd0});
        add_request(request_t'{rsf_pkg::CMD_POLL, 32'hFFFF_FFFF, 32'h0, 32'h0, 8'd2},
                    1'b1, outcome_t'{32'h0, 32'h0, rsf_pkg::PH_RUN, rsf_pkg::ST_PENDING,
                                     rsf_pkg::EXIT_NORMAL, 16'd0});
        // top unit dies: restarted alone
        add_request(request_t'{rsf_pkg::CMD_POLL, 32'h7FFF_FFFF, 32'h0, 32'h0, 8'd2},
                    1'b1, outcome_t'{32'h0, 32'h0, rsf_pkg::PH_RESTART, rsf_pkg::ST_PENDING,
                                     rsf_pkg::EXIT_NORMAL, 16'd1});
        add_request(request_t'{rsf_pkg::CMD_POLL, 32'h7FFF_FFFF, 32'h0, 32'h0, 8'd2},
                    1'b1, outcome_t'{32'h8000_0000, 32'h0, rsf_pkg::PH_RUN,
                                     rsf_pkg::ST_PENDING, rsf_pkg::EXIT_NORMAL, 16'd1});
        // second death hits the restart limit: everything alive is stopped
        add_request(request_t'{rsf_pkg::CMD_POLL, 32'hFFFF_FFFE, 32'h0, 32'h0, 8'd2},
                    1'b1, outcome_t'{32'h0, 32'hFFFF_FFFE, rsf_pkg::PH_SHUTDOWN,
                                     rsf_pkg::ST_PENDING, rsf_pkg::EXIT_LIMIT, 16'd1});
        add_request(request_t'{rsf_pkg::CMD_POLL, 32'h0000_0F00, 32'h0, 32'h0, 8'd2},
                    1'b0, none);
        add_request(request_t'{rsf_pkg::CMD_POLL, 32'h0, 32'h0, 32'h0, 8'd2},
                    1'b1, outcome_t'{32'h0, 32'h0, rsf_pkg::PH_DONE, rsf_pkg::ST_FINISHED,
                                     rsf_pkg::EXIT_LIMIT, 16'd1});
        add_request(request_t'{rsf_pkg::CMD_POLL, 32'h0, 32'h0, 32'h0, 8'd2},
                    1'b1, outcome_t'{32'h0, 32'h0, rsf_pkg::PH_DONE, rsf_pkg::ST_NOT_ACTIVE,
                                     rsf_pkg::EXIT_LIMIT, 16'd1});
        add_request(request_t'{CMD_RESERVED, 32'h0, 32'h0, 32'h0, 8'd2},
                    1'b1, outcome_t'{32'h0, 32'h0, rsf_pkg::PH_DONE, rsf_pkg::ST_NOT_ACTIVE,
                                     rsf_pkg::EXIT_LIMIT, 16'd1});
        // Too many units (clamped to 32), kinds cycling never/temporary/transient/permanent.
        add_setup(rsf_pkg::STRAT_ONE_FOR_ALL, 16'hFFFF, 6'd40, 64'h1B1B_1B1B_1B1B_1B1B);
        add_request(request_t'{rsf_pkg::CMD_ARM, 32'h0, 32'h0, 32'h0, 8'd2},
                    1'b1, outcome_t'{32'h0, 32'h0, rsf_pkg::PH_INIT, rsf_pkg::ST_ACCEPTED,
                                     rsf_pkg::EXIT_NORMAL, 16'd0});
        // start failure at unit 5 during init: the five started units are stopped
        add_request(request_t'{rsf_pkg::CMD_POLL, 32'h0, 32'h0, 32'h0000_0020, 8'hFF},
                    1'b1, outcome_t'{32'h1F, 32'h1F, rsf_pkg::PH_SHUTDOWN,
                                     rsf_pkg::ST_PENDING, 8'hFF, 16'd0});
        // stop during shutdown clears the exit code
        add_request(request_t'{rsf_pkg::CMD_STOP, 32'hA5A5_A5A5, 32'h0, 32'h0, 8'd2},
                    1'b1, outcome_t'{32'h0, 32'hA5A5_A5A5, rsf_pkg::PH_SHUTDOWN,
                                     rsf_pkg::ST_ACCEPTED, rsf_pkg::EXIT_NORMAL, 16'd0});
        // re-arm while still active
        add_request(request_t'{rsf_pkg::CMD_ARM, 32'h0, 32'h0, 32'h0, 8'd2},
                    1'b1, outcome_t'{32'h0, 32'h0, rsf_pkg::PH_INIT, rsf_pkg::ST_ACCEPTED,
                                     rsf_pkg::EXIT_NORMAL, 16'd0});
        add_request(request_t'{rsf_pkg::CMD_POLL, 32'h0, 32'h0, 32'h0, 8'd2}, 1'b0, none);
        add_request(request_t'{rsf_pkg::CMD_POLL, 32'hFFFF_FFF7, 32'h0, 32'h0, 8'd2},
                    1'b0, none);
        add_request(request_t'{rsf_pkg::CMD_POLL, 32'h0, 32'h0, 32'h0, 8'd2}, 1'b0, none);
        // restart fails at the top unit with an exit code below the usual range
        add_request(request_t'{rsf_pkg::CMD_POLL, 32'h0, 32'h0, 32'h8000_0000, 8'd1},
                    1'b0, none);
        add_setup(rsf_pkg::STRAT_REST_FOR_ONE, 16'd5, 6'd4, 64'd0);
        add_request(request_t'{rsf_pkg::CMD_ARM, 32'h0, 32'h0, 32'h0, 8'd0}, 1'b0, none);
        add_request(request_t'{rsf_pkg::CMD_POLL, 32'h0, 32'h0, 32'h0, 8'd2}, 1'b0, none);
        add_request(request_t'{rsf_pkg::CMD_POLL, 32'h0000_000D, 32'h0, 32'h0, 8'd2},
                    1'b0, none);
        add_request(request_t'{rsf_pkg::CMD_POLL, 32'h0000_0004, 32'h0, 32'h0, 8'd2},
                    1'b0, none);

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (script[j])
        begin
            if (script[j].is_setup)
                apply_setup(script[j].strat, script[j].maxr, script[j].ucnt, script[j].kinds);
            else
                send_request(script[j].req, script[j].typed, script[j].want, o);
        end

        // ---- random command streams, one register setting at a time -------------
        // A small unit model answers the polls: started units come up, stopped ones
        // go down after a random lag, and running units die now and then. Most
        // requests follow the protocol; a few are pure noise.
        for (int k = 0; k < SETTINGS_N; k++)
        begin
            strat = 2'(k);
            if (k == 3) strat = STRAT_RESERVED;
            case (k)
                0: begin ucnt = 6'd32; maxr = 16'hFFFF; end
                1: begin ucnt = 6'd5;  maxr = 16'd3;    end
                2: begin ucnt = 6'd1;  maxr = 16'd0;    end
                3: begin ucnt = 6'd0;  maxr = 16'd10;   end
                4: begin ucnt = 6'd45; maxr = 16'd2;    end
                5: begin ucnt = 6'd17; maxr = 16'hFFFF; end
                6: begin ucnt = 6'd63; maxr = 16'd1;    end
                default:
                begin
                    ucnt = 6'($urandom_range(63));
                    maxr = 16'($urandom_range(12));
                end
            endcase
            if (k == 1)
                kinds = '0;
            else if (k == 6)
                kinds = {32{KIND_NEVER}};
            else if (k[0])
                kinds = {$urandom, $urandom};
            else
                kinds = {$urandom, $urandom} & {$urandom, $urandom};
            apply_setup(strat, maxr, ucnt, kinds);
            quiet = (k == 2);

            for (int m = 0; m < PER_SETTING; m++)
            begin
                roll = $urandom_range(99);
                r.exit_ok = $urandom;
                r.err = 8'($urandom_range(2, 255));
                r.fails = '0;
                if (roll < 8)
                begin
                    r.cmd = 2'($urandom_range(3));
                    r.alive = $urandom;
                    r.fails = $urandom;
                    r.err = 8'($urandom);
                end
                else if (!sv_armed || m == 0 || roll < 10)
                begin
                    r.cmd = rsf_pkg::CMD_ARM;
                    r.alive = units_up;
                end
                else
                begin
                    r.cmd = (roll < 13) ? rsf_pkg::CMD_STOP : rsf_pkg::CMD_POLL;
                    if ($urandom_range(99) < ((sv_phase == rsf_pkg::PH_RUN) ? 30 : 5))
                        units_up[$urandom_range(31)] = 1'b0;
                    if ((sv_phase == rsf_pkg::PH_INIT || sv_phase == rsf_pkg::PH_RESTART) &&
                        $urandom_range(99) < 6)
                        r.fails = 32'd1 << $urandom_range(31);
                    r.alive = units_up | (units_lagging & $urandom);
                    units_lagging = units_lagging & $urandom;
                end
                send_request(r, 1'b0, none, o);
                units_up = (units_up | o.start) & ~o.stop;
                units_lagging = units_lagging | o.stop;
            end
            quiet = 1'b0;
        end

        cmd_valid <= 1'b0;
        while (outcome_q.size() != 0) @(posedge clk);
        repeat (10) @(posedge clk);

        $display("ran %0d requests (%0d results checked) over %0d register settings",
                 requests_sent, results_checked, SETTINGS_N + 3);
        $display("restart decisions taken: %0d, shutdowns run to completion: %0d",
                 restarts_seen, shutdowns_seen);
        if (mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
